### rtl/core/assert_macros.svh
// Assertion macros shared by the square root RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define NSR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when ante holds, cons must hold in the same cycle.
`define NSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication: when ante holds, cons must hold in the next cycle.
`define NSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/nsr_pkg.sv
// Package: widths, constants and controller/datapath interface types.
package nsr_pkg;

  localparam int DATA_W         = 32;
  localparam int FRAC_W         = 16;
  localparam int ROOT_W         = 25;
  localparam int TOL_W          = 16;
  localparam int MAG_W          = DATA_W - 1;
  localparam int DIVIDEND_W     = MAG_W + FRAC_W;
  localparam int DIV_STEPS      = DIVIDEND_W;
  localparam int CNT_W          = $clog2(DIV_STEPS);
  localparam int MAX_ITERATIONS = 32;
  localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);

  localparam logic [DATA_W-1:0] ONE_Q16        = 32'h0001_0000;
  localparam logic [ROOT_W-1:0] MINUS_ONE_ROOT = 25'h1FF_0000;
  localparam logic [TOL_W-1:0]  TOL_RESET      = 16'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STEP,
    ST_CHECK,
    ST_FIN
  } nsr_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // take the input beat, set up first division
    logic div_step;  // one restoring division step
    logic step;      // form the next guess
    logic finish;    // capture the result
    logic advance;   // next guess becomes the guess, restart division
    logic emit;      // move the result into the output register
  } nsr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic special;   // input needs no iteration
    logic div_last;  // final division step in progress
    logic conv;      // guess change within tolerance
    logic cap;       // iteration cap reached
    logic out_free;  // output register can take a result
  } nsr_stat_t;

endpackage

### rtl/core/nsr_ctrl.sv
// Controller state machine for the Newton square root.
`include "assert_macros.svh"

module nsr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              cfg_ready_o,
  input  nsr_pkg::nsr_stat_t stat_i,
  output nsr_pkg::nsr_cmd_t  cmd_o
);

  nsr_pkg::nsr_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nsr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nsr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.special ? nsr_pkg::ST_FIN : nsr_pkg::ST_DIV;
        end
      end
      nsr_pkg::ST_DIV: begin
        if (stat_i.div_last) begin
          state_d = nsr_pkg::ST_STEP;
        end
      end
      nsr_pkg::ST_STEP: begin
        state_d = nsr_pkg::ST_CHECK;
      end
      nsr_pkg::ST_CHECK: begin
        state_d = (stat_i.conv || stat_i.cap) ? nsr_pkg::ST_FIN : nsr_pkg::ST_DIV;
      end
      nsr_pkg::ST_FIN: begin
        if (stat_i.out_free) begin
          state_d = nsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nsr_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    unique case (state_q)
      nsr_pkg::ST_IDLE: begin
        in_stall_o  = 1'b0;
        cfg_ready_o = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      nsr_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      nsr_pkg::ST_STEP: begin
        cmd_o.step = 1'b1;
      end
      nsr_pkg::ST_CHECK: begin
        cmd_o.finish  = stat_i.conv || stat_i.cap;
        cmd_o.advance = !(stat_i.conv || stat_i.cap);
      end
      nsr_pkg::ST_FIN: begin
        cmd_o.emit = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  `NSR_ASSERT_NEXT(a_div_to_step, clk_i, rst_ni,
    state_q == nsr_pkg::ST_DIV && stat_i.div_last, state_q == nsr_pkg::ST_STEP,
    "division end did not lead to the step state")
  `NSR_ASSERT_NEXT(a_check_done, clk_i, rst_ni,
    state_q == nsr_pkg::ST_CHECK && (stat_i.conv || stat_i.cap), state_q == nsr_pkg::ST_FIN,
    "finished iteration did not go to result hand-off")

endmodule

### rtl/core/nsr_dpath.sv
// Datapath: radix-2 restoring divider, Newton update, convergence check, output register.
`include "assert_macros.svh"

module nsr_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  nsr_pkg::nsr_cmd_t                 cmd_i,
  output nsr_pkg::nsr_stat_t                stat_o,
  input  logic signed [nsr_pkg::DATA_W-1:0] value_i,
  input  logic                              cfg_we_i,
  input  logic [nsr_pkg::TOL_W-1:0]         tolerance_lsb_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic signed [nsr_pkg::ROOT_W-1:0] root_o,
  output logic                              capped_o
);

  // Control registers
  logic [nsr_pkg::TOL_W-1:0]  tol_q;
  logic [nsr_pkg::ITER_W-1:0] iter_q;
  logic [nsr_pkg::CNT_W-1:0]  cnt_q;
  logic                       out_vld_q;

  // Payload registers
  logic [nsr_pkg::MAG_W-1:0]      value_q;
  logic [nsr_pkg::DATA_W-1:0]     guess_q;
  logic [nsr_pkg::DATA_W-1:0]     next_q;
  logic [nsr_pkg::DATA_W-1:0]     rem_q;
  logic [nsr_pkg::DIVIDEND_W-1:0] dq_q;
  logic [nsr_pkg::ROOT_W-1:0]     res_root_q;
  logic                           res_cap_q;
  logic [nsr_pkg::ROOT_W-1:0]     out_root_q;
  logic                           out_cap_q;

  logic                           special;
  logic [nsr_pkg::DATA_W-1:0]     first_guess;
  logic [nsr_pkg::DATA_W-1:0]     divisor;
  logic [nsr_pkg::DATA_W:0]       rem_sh;
  logic                           ge;
  logic [nsr_pkg::DATA_W:0]       rem_sub;
  logic [nsr_pkg::DIVIDEND_W:0]   sum;
  logic [nsr_pkg::DATA_W-1:0]     diff;
  logic                           conv;
  logic                           cap;
  logic                           out_free;

  // Input classification and starting guess
  assign special = value_i[nsr_pkg::DATA_W-1] || (value_i == '0) ||
                   (value_i == nsr_pkg::ONE_Q16);
  assign first_guess = (value_i > nsr_pkg::ONE_Q16) ? value_i : nsr_pkg::ONE_Q16;

  // One restoring division step; a zero guess divides by one
  assign divisor = (guess_q == '0) ? nsr_pkg::DATA_W'(1) : guess_q;
  assign rem_sh  = {rem_q, dq_q[nsr_pkg::DIVIDEND_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  // Newton update: average of guess and quotient
  assign sum = {{(nsr_pkg::DIVIDEND_W + 1 - nsr_pkg::DATA_W){1'b0}}, guess_q} + {1'b0, dq_q};

  // Convergence and cap
  assign diff = (guess_q > next_q) ? (guess_q - next_q) : (next_q - guess_q);
  assign conv = diff <= {{(nsr_pkg::DATA_W - nsr_pkg::TOL_W){1'b0}}, tol_q};
  assign cap  = iter_q >= nsr_pkg::ITER_W'(nsr_pkg::MAX_ITERATIONS);

  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    stat_o          = '0;
    stat_o.special  = special;
    stat_o.div_last = cnt_q == nsr_pkg::CNT_W'(nsr_pkg::DIV_STEPS - 1);
    stat_o.conv     = conv;
    stat_o.cap      = cap;
    stat_o.out_free = out_free;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q     <= nsr_pkg::TOL_RESET;
      iter_q    <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= tolerance_lsb_i;
      end
      if (cmd_i.load) begin
        iter_q <= nsr_pkg::ITER_W'(1);
      end else if (cmd_i.advance) begin
        iter_q <= iter_q + nsr_pkg::ITER_W'(1);
      end
      if (cmd_i.load || cmd_i.advance) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + nsr_pkg::CNT_W'(1);
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i[nsr_pkg::MAG_W-1:0];
      guess_q <= first_guess;
      rem_q   <= '0;
      dq_q    <= {value_i[nsr_pkg::MAG_W-1:0], {nsr_pkg::FRAC_W{1'b0}}};
      if (value_i[nsr_pkg::DATA_W-1]) begin
        res_root_q <= nsr_pkg::MINUS_ONE_ROOT;
      end else begin
        res_root_q <= value_i[nsr_pkg::ROOT_W-1:0];
      end
      res_cap_q <= 1'b0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sub[nsr_pkg::DATA_W-1:0] : rem_sh[nsr_pkg::DATA_W-1:0];
      dq_q  <= {dq_q[nsr_pkg::DIVIDEND_W-2:0], ge};
    end else if (cmd_i.step) begin
      next_q <= sum[nsr_pkg::DATA_W:1];
    end else if (cmd_i.finish) begin
      res_root_q <= next_q[nsr_pkg::ROOT_W-1:0];
      res_cap_q  <= !conv;
    end else if (cmd_i.advance) begin
      guess_q <= next_q;
      rem_q   <= '0;
      dq_q    <= {value_q, {nsr_pkg::FRAC_W{1'b0}}};
    end
    if (cmd_i.emit) begin
      out_root_q <= res_root_q;
      out_cap_q  <= res_cap_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign root_o      = out_root_q;
  assign capped_o    = out_cap_q;

  `NSR_ASSERT(a_iter_bound, clk_i, rst_ni,
    iter_q <= nsr_pkg::ITER_W'(nsr_pkg::MAX_ITERATIONS),
    "iteration count passed the cap")
  `NSR_ASSERT_IMPL(a_emit_free, clk_i, rst_ni, cmd_i.emit, out_free,
    "result loaded over an undelivered beat")

endmodule

### rtl/core/newton_square_root.sv
// Top level: Newton-Raphson square root in signed Q16.16.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o    value_i (32 b signed)
//   out      output     out_valid_o/out_stall_i  root_o (25 b signed), capped_o
//   cfg      input      cfg_valid_i/cfg_ready_o  tolerance_lsb_i (16 b)
//
// Negative, zero and exactly-one inputs skip the iteration and go straight to the result.
// Otherwise each Newton step runs the 47-step restoring divider, then the update and the
// check, until the guess change is within tolerance or the iteration cap is reached.
// One item at a time; the next input beat is taken while a result waits.
// Reset sets the tolerance to one LSB; cfg writes are taken only when idle.
`include "assert_macros.svh"

module newton_square_root (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [nsr_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [nsr_pkg::ROOT_W-1:0] root_o,
  output logic                              capped_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [nsr_pkg::TOL_W-1:0]         tolerance_lsb_i
);

  nsr_pkg::nsr_cmd_t  cmd;
  nsr_pkg::nsr_stat_t stat;

  nsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  nsr_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .value_i         (value_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .tolerance_lsb_i (tolerance_lsb_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .root_o          (root_o),
    .capped_o        (capped_o)
  );

  `NSR_ASSERT_IMPL(a_cap_positive, clk_i, rst_ni, out_valid_o && capped_o,
    !root_o[nsr_pkg::ROOT_W-1], "capped result carries the negative-input code")
  `NSR_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o,
    "second beat accepted while one is in progress")

endmodule

### tb/sv/nsr_root_checker.sv
// Checker for the Newton square root block: predicts every result beat and compares it.
module nsr_root_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic signed [nsr_pkg::DATA_W-1:0] value_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [nsr_pkg::ROOT_W-1:0] root_i,
  input  logic                              capped_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [nsr_pkg::TOL_W-1:0]         tolerance_lsb_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);
  import nsr_pkg::*;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              capped;
  } root_beat_t;

  root_beat_t        roots_q[$];
  root_beat_t        head_beat;
  logic [TOL_W-1:0]  tolerance_q;

  // One truncated Newton step: (guess + (value << 16) / guess) / 2
  function automatic logic [63:0] newton_step(logic [63:0] scaled, logic [63:0] guess);
    logic [63:0] divisor;
    divisor = (guess == 64'd0) ? 64'd1 : guess;
    return (guess + scaled / divisor) >> 1;
  endfunction

  // Square root of one Q16.16 radicand under the given tolerance
  function automatic root_beat_t predict_root(logic [DATA_W-1:0] radicand,
                                              logic [TOL_W-1:0] tol);
    root_beat_t  res;
    logic [63:0] scaled;
    logic [63:0] guess;
    logic [63:0] next;
    logic [63:0] diff;
    int unsigned iters;
    bit          done;
    res.capped = 1'b0;
    if (radicand[DATA_W-1]) begin
      res.root = MINUS_ONE_ROOT;
    end else if (radicand == '0 || radicand == ONE_Q16) begin
      res.root = radicand[ROOT_W-1:0];
    end else begin
      scaled = {32'd0, radicand} << FRAC_W;
      guess  = (radicand > ONE_Q16) ? {32'd0, radicand} : {32'd0, ONE_Q16};
      next   = newton_step(scaled, guess);
      iters  = 1;
      done   = 1'b0;
      while (!done) begin
        diff = (guess > next) ? guess - next : next - guess;
        if (diff <= {48'd0, tol}) begin
          done = 1'b1;
        end else if (iters >= MAX_ITERATIONS) begin
          // still moving when the cap is hit: last guess goes out flagged
          res.capped = 1'b1;
          done       = 1'b1;
        end else begin
          guess = next;
          next  = newton_step(scaled, guess);
          iters++;
        end
      end
      res.root = next[ROOT_W-1:0];
    end
    return res;
  endfunction

  task automatic report_failure(string msg);
    $display("root checker: %s", msg);
    fail_count_o++;
  endtask

  // Result beats are checked before the input beat of the same edge is queued
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roots_q.delete();
      tolerance_q  = TOL_RESET;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (roots_q.size() == 0) begin
          report_failure($sformatf("result root %h capped %b with none outstanding",
                                   root_i, capped_i));
        end else begin
          head_beat = roots_q.pop_front();
          if (root_i !== head_beat.root)
            report_failure($sformatf("root expected %h got %h", head_beat.root, root_i));
          if (capped_i !== head_beat.capped)
            report_failure($sformatf("capped expected %b got %b (root %h)",
                                     head_beat.capped, capped_i, head_beat.root));
        end
      end
      if (in_valid_i && !in_stall_i)
        roots_q.push_back(predict_root(value_i, tolerance_q));
      if (cfg_valid_i && cfg_ready_i)
        tolerance_q = tolerance_lsb_i;
      pending_o = roots_q.size();
    end
  end

endmodule

### tb/sv/tb_top.sv
// Testbench top for the Newton square root block: clock, reset, stimulus and verdict.
module tb_top;
  import nsr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [ROOT_W-1:0] root;
  logic                     capped;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [TOL_W-1:0]         tolerance;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;
  int unsigned fail_count;
  int unsigned pending;

  logic [DATA_W-1:0] directed_values [0:19];

  always #2 clk = ~clk;

  newton_square_root u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .value_i         (value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .root_o          (root),
    .capped_o        (capped),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .tolerance_lsb_i (tolerance)
  );

  nsr_root_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .value_i         (value),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .root_i          (root),
    .capped_i        (capped),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .tolerance_lsb_i (tolerance),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: cycles without any beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mix of radicands: full range, near one, near the top, exact squares, negatives, shifted-down and tiny values
  function automatic logic [DATA_W-1:0] random_radicand();
    logic [DATA_W-1:0] v;
    int unsigned       k;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom();
      3:       v = $urandom_range(0, 131072);
      4:       v = 32'd65504 + $urandom_range(0, 64);
      5:       v = 32'h7FFF_FFFF - $urandom_range(0, 65535);
      6: begin
        k = $urandom_range(0, 46340);
        v = k * k;
      end
      7:       v = 32'h8000_0000 | $urandom();
      8:       v = $urandom() >> $urandom_range(1, 31);
      default: v = $urandom_range(1, 16);
    endcase
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat
  task automatic send_radicand(input logic [DATA_W-1:0] v);
    int unsigned gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = ($urandom_range(15) == 0) ? $urandom_range(1, 900) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_radicand(random_radicand());
  endtask

  // Tolerance is only written once every root has come back
  task automatic write_tolerance(input logic [TOL_W-1:0] tol);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    tolerance <= tol;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    value          = '0;
    cfg_valid      = 1'b0;
    tolerance      = '0;
    send_idle_pct  = 36;
    recv_stall_pct = 56;
    // zero, one, negatives, extremes, fractions below one, values above one, alternating bits
    directed_values = '{32'h0000_0000, ONE_Q16, 32'hFFFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0002, 32'h0000_FFFF,
                        32'h0001_0001, 32'h0002_0000, 32'h0004_0000, 32'h0000_8000,
                        32'h0000_4000, 32'h7FFF_0000, 32'h4000_0000, 32'hFFFF_0000,
                        32'h0064_0000, 32'h0001_8000, 32'h5555_5555, 32'h2AAA_AAAA};
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset tolerance of one LSB
    foreach (directed_values[i]) send_radicand(directed_values[i]);

    // zero tolerance: oscillating guesses run into the cap
    write_tolerance(16'd0);
    send_random(40);
    write_tolerance(16'hFFFF);
    send_random(120);
    write_tolerance(TOL_W'($urandom_range(2, 64)));
    send_random(120);

    send_idle_pct  = 56;
    recv_stall_pct = 36;
    write_tolerance(16'd1);
    send_random(150);
    write_tolerance(TOL_W'($urandom_range(0, 65535)));
    send_random(130);

    // back-to-back beats on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_tolerance(TOL_W'($urandom_range(1, 8)));
    send_random(140);
    write_tolerance(TOL_RESET);
    send_random(130);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/nsr_pkg.sv
rtl/core/nsr_ctrl.sv
rtl/core/nsr_dpath.sv
rtl/core/newton_square_root.sv
tb/sv/nsr_root_checker.sv
tb/sv/tb_top.sv
